@@ sv/http_chunked_decoder_macros.svh @@
// Assertion macros used by the verification file of the chunked decoder.
// Depends on nothing; expects i_clk and i_rst_n in the including scope.
`ifndef HTTP_CHUNKED_DECODER_MACROS_SVH
`define HTTP_CHUNKED_DECODER_MACROS_SVH

// Checked on every rising edge while out of reset.
`define CHD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define CHD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ sv/chd_pkg.sv @@
// Shared types and constants of the chunked transfer decoder.
// No dependencies.
package chd_pkg;

    // Default width of the chunk size counters
    localparam int SIZE_WIDTH_DEF = 32;

    // Result kind codes
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // Characters of interest
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;

    // One result beat as handed from the parser to the output register
    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] payload;
    } t_result;

endpackage

@@ sv/chd_in_if.sv @@
// Input channel of the chunked decoder: one body byte per beat.
// No dependencies.
interface chd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

@@ sv/chd_out_if.sv @@
// Output channel of the chunked decoder: one result per beat.
// No dependencies.
interface chd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] payload_byte;

    modport source (output valid, output result_kind, output payload_byte, input ready);
    modport sink   (input valid, input result_kind, input payload_byte, output ready);
endinterface

@@ sv/http_chunked_decoder.sv @@
// Top level of the HTTP chunked transfer decoder.
// Depends on chd_pkg, chd_in_if, chd_out_if, chd_parser, chd_out_stage.
//
//   Channel  Dir  Payload                     Per beat
//   i_in     in   byte_value[7:0], last_byte  one body byte
//   o_out    out  result_kind[1:0], payload   zero or one result per byte
//
// One byte per clock while the result register can take it: the parser
// updates its state and the result register in the same cycle, so a result
// shows in the cycle after its byte is taken. i_in.ready is high whenever
// the result register is empty or drains this cycle; a stalled output holds
// one result and blocks input only then. Synchronous active-low reset
// returns the parser to the start of a size line and empties the result register.
module http_chunked_decoder #(
    parameter int SIZE_WIDTH = chd_pkg::SIZE_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    chd_in_if.sink     i_in,
    chd_out_if.source  o_out
);

    chd_pkg::t_result res;
    logic             stage_ready;
    logic             accept;

    assign i_in.ready = stage_ready;
    assign accept     = i_in.valid && stage_ready;

    chd_parser #(
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in.byte_value),
        .i_last   (i_in.last_byte),
        .o_res    (res)
    );

    chd_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_res    (res),
        .o_ready  (stage_ready),
        .o_out    (o_out)
    );

endmodule

@@ sv/chd_parser.sv @@
// Size-line parser and chunk counter of the chunked decoder.
// Depends on chd_pkg.
module chd_parser #(
    parameter int SIZE_WIDTH = chd_pkg::SIZE_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output chd_pkg::t_result o_res
);

    typedef enum logic [3:0] {
        PH_LEAD   = 4'd0,
        PH_ZERO   = 4'd1,
        PH_XSEEN  = 4'd2,
        PH_DIGITS = 4'd3,
        PH_TAIL   = 4'd4,
        PH_TAILCR = 4'd5,
        PH_DATA   = 4'd6,
        PH_SKIP1  = 4'd7,
        PH_SKIP2  = 4'd8,
        PH_SINK   = 4'd9
    } t_phase;

    t_phase                  r_phase, n_phase;
    logic [SIZE_WIDTH-1:0]   r_acc, n_acc;
    logic [SIZE_WIDTH-1:0]   r_rem, n_rem;

    logic       is_hex;
    logic [3:0] digit;
    logic       is_blank;
    logic       res_valid;
    logic [1:0] res_kind;

    // Hex digit and blank classification
    always_comb begin
        is_hex = 1'b1;
        digit  = 4'd0;
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            digit = 4'(i_byte - 8'h30);
        end else if (i_byte >= 8'h61 && i_byte <= 8'h66) begin
            digit = 4'(i_byte - 8'h57);
        end else if (i_byte >= 8'h41 && i_byte <= 8'h46) begin
            digit = 4'(i_byte - 8'h37);
        end else begin
            is_hex = 1'b0;
        end
        is_blank = (i_byte == chd_pkg::CH_SPACE) ||
                   (i_byte >= chd_pkg::CH_TAB && i_byte <= chd_pkg::CH_CR);
    end

    // Next state and result for the byte on the input
    always_comb begin
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_rem     = r_rem;
        res_valid = 1'b0;
        res_kind  = chd_pkg::KIND_DATA;

        unique case (r_phase)
            PH_LEAD: begin
                if (is_blank) begin
                    n_phase = PH_LEAD;
                end else if (i_byte == chd_pkg::CH_ZERO) begin
                    n_acc   = '0;
                    n_phase = PH_ZERO;
                end else if (is_hex) begin
                    n_acc   = SIZE_WIDTH'(digit);
                    n_phase = PH_DIGITS;
                end else begin
                    res_valid = 1'b1;
                    res_kind  = chd_pkg::KIND_ERR;
                end
            end
            PH_ZERO: begin
                if (i_byte == chd_pkg::CH_X_LO || i_byte == chd_pkg::CH_X_UP) begin
                    n_phase = PH_XSEEN;
                end else if (is_hex) begin
                    n_acc   = SIZE_WIDTH'(digit);
                    n_phase = PH_DIGITS;
                end else begin
                    n_phase = (i_byte == chd_pkg::CH_CR) ? PH_TAILCR : PH_TAIL;
                end
            end
            PH_XSEEN: begin
                if (is_hex) begin
                    n_acc   = SIZE_WIDTH'(digit);
                    n_phase = PH_DIGITS;
                end else begin
                    n_phase = (i_byte == chd_pkg::CH_CR) ? PH_TAILCR : PH_TAIL;
                end
            end
            PH_DIGITS: begin
                if (is_hex) begin
                    // top nibble busy: another digit would overflow
                    if (r_acc[SIZE_WIDTH-1 -: 4] != 4'd0) begin
                        res_valid = 1'b1;
                        res_kind  = chd_pkg::KIND_ERR;
                    end else begin
                        n_acc = {r_acc[SIZE_WIDTH-5:0], digit};
                    end
                end else begin
                    n_phase = (i_byte == chd_pkg::CH_CR) ? PH_TAILCR : PH_TAIL;
                end
            end
            PH_TAIL: begin
                n_phase = (i_byte == chd_pkg::CH_CR) ? PH_TAILCR : PH_TAIL;
            end
            PH_TAILCR: begin
                if (i_byte == chd_pkg::CH_LF) begin
                    if (r_acc == '0) begin
                        res_valid = 1'b1;
                        res_kind  = chd_pkg::KIND_DONE;
                    end else begin
                        n_rem   = r_acc;
                        n_phase = PH_DATA;
                    end
                end else begin
                    n_phase = (i_byte == chd_pkg::CH_CR) ? PH_TAILCR : PH_TAIL;
                end
            end
            PH_DATA: begin
                res_valid = 1'b1;
                res_kind  = chd_pkg::KIND_DATA;
                n_rem     = r_rem - SIZE_WIDTH'(1);
                if (r_rem == SIZE_WIDTH'(1)) begin
                    n_phase = PH_SKIP1;
                end
            end
            PH_SKIP1: begin
                n_phase = PH_SKIP2;
            end
            PH_SKIP2: begin
                n_acc   = '0;
                n_phase = PH_LEAD;
            end
            default: begin
                // after the end of a message: ignore bytes
                n_phase = r_phase;
            end
        endcase

        // done or error ends the message
        if (res_valid && res_kind != chd_pkg::KIND_DATA) begin
            n_phase = PH_SINK;
        end

        // last byte: early end is an error, then rearm
        if (i_last) begin
            if (r_phase != PH_SINK && !(res_valid && res_kind == chd_pkg::KIND_DONE)) begin
                res_valid = 1'b1;
                res_kind  = chd_pkg::KIND_ERR;
            end
            n_phase = PH_LEAD;
            n_acc   = '0;
            n_rem   = '0;
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_acc   <= '0;
            r_rem   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_rem   <= n_rem;
        end
    end

    assign o_res.valid   = res_valid;
    assign o_res.kind    = res_kind;
    assign o_res.payload = (res_kind == chd_pkg::KIND_DATA) ? i_byte : 8'd0;

endmodule

@@ sv/chd_out_stage.sv @@
// Result register of the chunked decoder, drives the output channel.
// Depends on chd_pkg and chd_out_if.
module chd_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  chd_pkg::t_result i_res,
    output logic             o_ready,
    chd_out_if.source        o_out
);

    logic       r_valid;
    logic [1:0] r_kind;
    logic [7:0] r_payload;

    // Free or emptying this cycle: can take the next beat
    assign o_ready = !r_valid || o_out.ready;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_accept) begin
            r_valid <= i_res.valid;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_accept && i_res.valid) begin
            r_kind    <= i_res.kind;
            r_payload <= i_res.payload;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.result_kind  = r_kind;
    assign o_out.payload_byte = r_payload;

endmodule

@@ sv/chd_checker.sv @@
// Port-level checks of the chunked decoder, bound to the top level.
// Depends on chd_pkg and http_chunked_decoder_macros.svh.
`include "http_chunked_decoder_macros.svh"

module chd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_kind,
    input logic [7:0] i_out_payload
);

    // A stalled result beat holds
    `CHD_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_kind) && $stable(i_out_payload), "stalled result changed")

    // Only the three defined result kinds appear
    `CHD_ASSERT(a_kind_legal, i_out_valid |-> i_out_kind != 2'd3, "illegal result kind")

    // Done and error beats carry a zero payload
    `CHD_ASSERT(a_payload_zero, i_out_valid && i_out_kind != chd_pkg::KIND_DATA |-> i_out_payload == 8'd0, "nonzero payload on status beat")

    // Reset empties the result register
    `CHD_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !i_out_valid, "result valid after reset")

endmodule

bind http_chunked_decoder chd_checker u_chd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_kind    (o_out.result_kind),
    .i_out_payload (o_out.payload_byte)
);
